// File: hdl/fdc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command/status types and CRC step for the frame deframer.
package fdc_pkg;

   localparam logic [7:0]  SOF_A    = 8'hAA;
   localparam logic [7:0]  SOF_B    = 8'h55;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] ERR_MAX  = 16'hFFFF;

   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int LEN_W     = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_VERSION   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD_LEN = 1'b1;

   localparam logic [2:0] HDR_VERSION = 3'd0;
   localparam logic [2:0] HDR_TYPE    = 3'd1;
   localparam logic [2:0] HDR_FLAGS   = 3'd2;
   localparam logic [2:0] HDR_SEQ_LO  = 3'd3;
   localparam logic [2:0] HDR_SEQ_HI  = 3'd4;
   localparam logic [2:0] HDR_LEN_LO  = 3'd5;
   localparam logic [2:0] HDR_LEN_HI  = 3'd6;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_VERSION = 2'd1;
   localparam logic [1:0] ST_TOO_LONG    = 2'd2;
   localparam logic [1:0] ST_CRC_BAD     = 2'd3;

   typedef struct packed {
      logic       hdr_load;
      logic [2:0] hdr_idx;
      logic       crc_clear;
      logic       crc_step;
      logic       idx_clear;
      logic       pay_write;
      logic       crc_lo_load;
      logic       err_load;
      logic [1:0] err_code;
      logic       empty_load;
      logic       res_load;
   } fdc_cmd_type;

   typedef struct packed {
      logic sof_a;
      logic sof_b;
      logic version_bad;
      logic hdr_len_bad;
      logic hdr_len_zero;
      logic len_zero;
      logic idx_last;
      logic crc_bad;
      logic out_last;
   } fdc_sts_type;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/frame_deframer_crc16_core.sv
`timescale 1ns / 1ps
// Top level of the start-of-frame, length-framed deframer with CRC-16/CCITT-FALSE check.
//
// req_* carries one received byte per transaction (valid/ready). The core hunts for
// 0xAA 0x55, takes a 7-byte header (version, type, flags, seq LE, length LE), buffers
// up to MAX_PAYLOAD payload bytes and checks the little-endian CRC that follows.
// rsp_* delivers results: a good frame gives one transaction per payload byte (one
// transaction with byte_valid low for an empty frame), a bad frame gives one error
// transaction with its status code; rsp_last marks the end of each run.
// csr_* writes frame_version (index 0) and max_payload_len (index 1), idle only.
// Throughput: one byte per cycle while hunting and receiving. The CRC byte that ends a
// frame is followed by its results; req_ready stays low until the last one is taken.
// Each payload result of a good frame passes S_LOAD (buffer read into the output
// register), then S_RESULT (presentation); an error result is presented in the cycle
// after the closing byte. A stalled rsp_ready holds the result and blocks further input.
// Reset: hunting for the first start byte, error count zero, frame_version 1,
// max_payload_len 64; the payload buffer needs no clearing.
module frame_deframer_crc16_core #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_frame_type,
   output logic [7:0]                    rsp_frame_flags,
   output logic [15:0]                   rsp_sequence_res,
   output logic [fdc_pkg::LEN_W-1:0]     rsp_payload_length,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic [15:0]                   rsp_error_total,
   input  logic                          csr_write_en,
   input  logic [fdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fdc_pkg::CFG_W-1:0]     csr_wdata
);
   import fdc_pkg::*;

   fdc_cmd_type cmd;
   fdc_sts_type sts;

   fdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fdc_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rx_byte            (req_rx_byte),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_status         (rsp_status),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_frame_flags    (rsp_frame_flags),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last           (rsp_last),
      .rsp_error_total    (rsp_error_total)
   );

endmodule

// File: hdl/fdc_ctrl.sv
`timescale 1ns / 1ps
// Deframer controller: hunt, header, payload, CRC and result sequencing.
module fdc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fdc_pkg::fdc_cmd_type cmd,
   input  fdc_pkg::fdc_sts_type sts
);
   import fdc_pkg::*;

   typedef enum logic [2:0] {
      S_HUNT0,
      S_HUNT1,
      S_HEADER,
      S_PAYLOAD,
      S_CRC0,
      S_CRC1,
      S_LOAD,
      S_RESULT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] header_index_ff, header_index_in;
   logic       ready_ff, valid_ff;
   logic       accept;

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
   assign accept    = req_valid & ready_ff;

   always_comb begin
      cmd             = '0;
      state_in        = state_ff;
      header_index_in = header_index_ff;
      unique case (state_ff)
         S_HUNT0: begin
            if (accept) begin
               state_in = sts.sof_a ? S_HUNT1 : S_HUNT0;
            end
         end
         S_HUNT1: begin
            if (accept) begin
               if (sts.sof_b) begin
                  state_in        = S_HEADER;
                  header_index_in = HDR_VERSION;
                  cmd.crc_clear   = 1'b1;
               end else begin
                  state_in = sts.sof_a ? S_HUNT1 : S_HUNT0;
               end
            end
         end
         S_HEADER: begin
            if (accept) begin
               cmd.hdr_load = 1'b1;
               cmd.hdr_idx  = header_index_ff;
               cmd.crc_step = 1'b1;
               if (header_index_ff == HDR_LEN_HI) begin
                  header_index_in = HDR_VERSION;
                  if (sts.version_bad) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ST_BAD_VERSION;
                     state_in     = S_RESULT;
                  end else if (sts.hdr_len_bad) begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ST_TOO_LONG;
                     state_in     = S_RESULT;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = sts.hdr_len_zero ? S_CRC0 : S_PAYLOAD;
                  end
               end else begin
                  header_index_in = header_index_ff + 3'd1;
               end
            end
         end
         S_PAYLOAD: begin
            if (accept) begin
               cmd.crc_step  = 1'b1;
               cmd.pay_write = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_CRC0;
               end
            end
         end
         S_CRC0: begin
            if (accept) begin
               cmd.crc_lo_load = 1'b1;
               state_in        = S_CRC1;
            end
         end
         S_CRC1: begin
            if (accept) begin
               state_in = S_RESULT;
               if (sts.crc_bad) begin
                  cmd.err_load = 1'b1;
                  cmd.err_code = ST_CRC_BAD;
               end else if (sts.len_zero) begin
                  cmd.empty_load = 1'b1;
               end else begin
                  cmd.idx_clear = 1'b1;
                  state_in      = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cmd.res_load = 1'b1;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_ready) begin
               state_in = sts.out_last ? S_HUNT0 : S_LOAD;
            end
         end
         default: begin
            state_in = S_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_HUNT0;
         header_index_ff <= HDR_VERSION;
         ready_ff        <= 1'b0;
         valid_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         header_index_ff <= header_index_in;
         ready_ff        <= (state_in != S_LOAD) && (state_in != S_RESULT);
         valid_ff        <= (state_in == S_RESULT);
      end
   end

endmodule

// File: hdl/fdc_dp.sv
`timescale 1ns / 1ps
// Deframer datapath: config registers, header capture, CRC, payload buffer, result register.
module fdc_dp #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [fdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdc_pkg::CFG_W-1:0]        csr_wdata,
   input  logic [7:0]                       rx_byte,
   input  fdc_pkg::fdc_cmd_type             cmd,
   output fdc_pkg::fdc_sts_type             sts,
   output logic [1:0]                       rsp_status,
   output logic [7:0]                       rsp_frame_type,
   output logic [7:0]                       rsp_frame_flags,
   output logic [15:0]                      rsp_sequence_res,
   output logic [fdc_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_byte_valid,
   output logic                             rsp_last,
   output logic [15:0]                      rsp_error_total
);
   import fdc_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0]       frame_version_ff;
   logic [LEN_W-1:0] max_len_ff;
   logic [7:0]       version_ff, type_ff, flags_ff, seq_lo_ff, seq_hi_ff;
   logic [7:0]       len_lo_ff, len_hi_ff, crc_lo_ff;
   logic [15:0]      crc_ff, errors_ff, errors_inc;
   logic [LEN_W-1:0] idx_ff, idx_next, limit;
   logic [15:0]      len_full, hdr_len;
   logic [7:0]       mem [MAX_PAYLOAD];

   logic [1:0]       status_ff;
   logic [7:0]       type_out_ff, flags_out_ff, byte_out_ff;
   logic [15:0]      seq_out_ff, err_out_ff;
   logic [LEN_W-1:0] len_out_ff;
   logic             valid_out_ff, last_out_ff;

   assign limit      = (max_len_ff > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : max_len_ff;
   assign len_full   = {len_hi_ff, len_lo_ff};
   assign hdr_len    = {rx_byte, len_lo_ff};
   assign idx_next   = idx_ff + LEN_W'(1);
   assign errors_inc = (errors_ff == ERR_MAX) ? errors_ff : errors_ff + 16'd1;

   always_comb begin
      sts.sof_a        = (rx_byte == SOF_A);
      sts.sof_b        = (rx_byte == SOF_B);
      sts.version_bad  = (version_ff != frame_version_ff);
      sts.hdr_len_bad  = (hdr_len > {{(16-LEN_W){1'b0}}, limit});
      sts.hdr_len_zero = (hdr_len == 16'd0);
      sts.len_zero     = (len_full == 16'd0);
      sts.idx_last     = ({{(16-LEN_W){1'b0}}, idx_next} >= len_full)
                         || (idx_next >= LEN_W'(MAX_PAYLOAD));
      sts.crc_bad      = ({rx_byte, crc_lo_ff} != crc_ff);
      sts.out_last     = last_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_version_ff <= 8'd1;
         max_len_ff       <= LEN_W'(64);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_VERSION:   frame_version_ff <= csr_wdata;
            CSR_MAX_PAYLOAD_LEN: max_len_ff       <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hdr_load) begin
         unique case (cmd.hdr_idx)
            HDR_VERSION: version_ff <= rx_byte;
            HDR_TYPE:    type_ff    <= rx_byte;
            HDR_FLAGS:   flags_ff   <= rx_byte;
            HDR_SEQ_LO:  seq_lo_ff  <= rx_byte;
            HDR_SEQ_HI:  seq_hi_ff  <= rx_byte;
            HDR_LEN_LO:  len_lo_ff  <= rx_byte;
            HDR_LEN_HI:  len_hi_ff  <= rx_byte;
            default: ;
         endcase
      end
      if (cmd.crc_lo_load) begin
         crc_lo_ff <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         idx_ff    <= '0;
         errors_ff <= '0;
      end else begin
         if (cmd.crc_clear) begin
            crc_ff <= CRC_INIT;
         end else if (cmd.crc_step) begin
            crc_ff <= crc16_step(crc_ff, rx_byte);
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.pay_write || cmd.res_load) begin
            idx_ff <= idx_next;
         end
         if (cmd.err_load) begin
            errors_ff <= errors_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pay_write) begin
         mem[idx_ff[AW-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_load) begin
         status_ff    <= cmd.err_code;
         type_out_ff  <= '0;
         flags_out_ff <= '0;
         seq_out_ff   <= '0;
         len_out_ff   <= '0;
         byte_out_ff  <= '0;
         valid_out_ff <= 1'b0;
         last_out_ff  <= 1'b1;
         err_out_ff   <= errors_inc;
      end else if (cmd.empty_load || cmd.res_load) begin
         status_ff    <= ST_OK;
         type_out_ff  <= type_ff;
         flags_out_ff <= flags_ff;
         seq_out_ff   <= {seq_hi_ff, seq_lo_ff};
         len_out_ff   <= len_full[LEN_W-1:0];
         byte_out_ff  <= cmd.res_load ? mem[idx_ff[AW-1:0]] : 8'd0;
         valid_out_ff <= cmd.res_load;
         last_out_ff  <= cmd.empty_load || sts.idx_last;
         err_out_ff   <= errors_ff;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_frame_type     = type_out_ff;
   assign rsp_frame_flags    = flags_out_ff;
   assign rsp_sequence_res   = seq_out_ff;
   assign rsp_payload_length = len_out_ff;
   assign rsp_payload_byte   = byte_out_ff;
   assign rsp_byte_valid     = valid_out_ff;
   assign rsp_last           = last_out_ff;
   assign rsp_error_total    = err_out_ff;

endmodule

// File: tb/frame_deframer_crc16_core_test.sv
`timescale 1ns / 1ps
// Testbench for the deframer core: frame stimulus, scoreboard with predictor, and idle control.
module frame_deframer_crc16_core_test;
   import fdc_pkg::*;

   localparam int MAX_PAYLOAD   = 64;
   localparam int HEADER_BYTES  = 7;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 12;

   typedef enum logic [2:0] {
      HUNT_AA, HUNT_55, TAKE_HEADER, TAKE_PAYLOAD, TAKE_CRC_LO, TAKE_CRC_HI
   } rx_phase_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       frame_type;
      logic [7:0]       frame_flags;
      logic [15:0]      sequence_res;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_byte;
      logic             byte_valid;
      logic             last;
      logic [15:0]      error_total;
   } frame_result_type;

   class frame_scoreboard;
      logic [7:0]       version_req;
      logic [6:0]       len_limit_reg;
      rx_phase_type     phase;
      int unsigned      hdr_count;
      logic [7:0]       version_hold;
      logic [7:0]       type_hold;
      logic [7:0]       flags_hold;
      logic [15:0]      seq_hold;
      logic [15:0]      length_hold;
      logic [6:0]       pay_count;
      logic [15:0]      crc_acc;
      logic [7:0]       crc_lo;
      logic [7:0]       pay_buf [MAX_PAYLOAD];
      logic [15:0]      error_count;
      frame_result_type pending_q [$];
      int unsigned      bytes_taken;
      int unsigned      results_seen;
      int unsigned      good_frames;
      int unsigned      bad_frames;
      int unsigned      mismatches;

      function new();
         version_req   = 8'd1;
         len_limit_reg = 7'd64;
         phase         = HUNT_AA;
         hdr_count     = 0;
         version_hold  = '0;
         type_hold     = '0;
         flags_hold    = '0;
         seq_hold      = '0;
         length_hold   = '0;
         pay_count     = '0;
         crc_acc       = CRC_INIT;
         crc_lo        = '0;
         error_count   = '0;
         bytes_taken   = 0;
         results_seen  = 0;
         good_frames   = 0;
         bad_frames    = 0;
         mismatches    = 0;
      endfunction

      function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
               crc = crc ^ CRC_POLY;
            end
         end
         return crc;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == CSR_FRAME_VERSION) begin
            version_req = value;
         end else if (idx == CSR_MAX_PAYLOAD_LEN) begin
            len_limit_reg = value[6:0];
         end
      endfunction

      function bit hunting();
         return phase == HUNT_AA;
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      function void push_error(logic [1:0] code);
         frame_result_type r;
         if (error_count != ERR_MAX) begin
            error_count++;
         end
         r             = '0;
         r.status      = code;
         r.last        = 1'b1;
         r.error_total = error_count;
         pending_q.insert(pending_q.size(), r);
         phase = HUNT_AA;
         bad_frames++;
      endfunction

      function void note_byte(logic [7:0] b);
         int unsigned      cap;
         int unsigned      n;
         frame_result_type r;
         bytes_taken++;
         case (phase)
            HUNT_55: begin
               if (b == SOF_B) begin
                  phase     = TAKE_HEADER;
                  hdr_count = 0;
                  crc_acc   = CRC_INIT;
               end else begin
                  phase = (b == SOF_A) ? HUNT_55 : HUNT_AA;
               end
            end
            TAKE_HEADER: begin
               crc_acc = crc_update(crc_acc, b);
               case (hdr_count[2:0])
                  HDR_VERSION: version_hold = b;
                  HDR_TYPE:    type_hold = b;
                  HDR_FLAGS:   flags_hold = b;
                  HDR_SEQ_LO:  seq_hold = {8'h00, b};
                  HDR_SEQ_HI:  seq_hold[15:8] = b;
                  HDR_LEN_LO:  length_hold = {8'h00, b};
                  default:     length_hold[15:8] = b;
               endcase
               hdr_count++;
               if (hdr_count == HEADER_BYTES) begin
                  hdr_count = 0;
                  cap = (len_limit_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : len_limit_reg;
                  if (version_hold != version_req) begin
                     push_error(ST_BAD_VERSION);
                  end else if (length_hold > cap) begin
                     push_error(ST_TOO_LONG);
                  end else begin
                     pay_count = '0;
                     phase     = (length_hold == 0) ? TAKE_CRC_LO : TAKE_PAYLOAD;
                  end
               end
            end
            TAKE_PAYLOAD: begin
               crc_acc = crc_update(crc_acc, b);
               if (pay_count < MAX_PAYLOAD) begin
                  pay_buf[pay_count[5:0]] = b;
               end
               pay_count++;
               if (pay_count >= length_hold || pay_count >= MAX_PAYLOAD) begin
                  phase = TAKE_CRC_LO;
               end
            end
            TAKE_CRC_LO: begin
               crc_lo = b;
               phase  = TAKE_CRC_HI;
            end
            TAKE_CRC_HI: begin
               if ({b, crc_lo} != crc_acc) begin
                  push_error(ST_CRC_BAD);
               end else begin
                  phase = HUNT_AA;
                  n     = (length_hold > MAX_PAYLOAD) ? MAX_PAYLOAD : length_hold;
                  good_frames++;
                  for (int k = 0; k == 0 || k < n; k++) begin
                     r.status         = ST_OK;
                     r.frame_type     = type_hold;
                     r.frame_flags    = flags_hold;
                     r.sequence_res   = seq_hold;
                     r.payload_length = LEN_W'(n);
                     r.payload_byte   = (n != 0) ? pay_buf[k] : 8'h00;
                     r.byte_valid     = (n != 0);
                     r.last           = (k + 1 >= n);
                     r.error_total    = error_count;
                     pending_q.insert(pending_q.size(), r);
                  end
               end
            end
            default: begin
               phase = (b == SOF_A) ? HUNT_55 : HUNT_AA;
            end
         endcase
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         mismatches++;
         $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      endtask

      task check_result(frame_result_type got);
         frame_result_type want;
         results_seen++;
         if (pending_q.size() == 0) begin
            report("result with nothing pending", 16'(got.status), 16'd0);
            return;
         end
         want = pending_q.pop_front();
         if (got.status != want.status)
            report("status", 16'(got.status), 16'(want.status));
         if (got.frame_type != want.frame_type)
            report("frame_type", 16'(got.frame_type), 16'(want.frame_type));
         if (got.frame_flags != want.frame_flags)
            report("frame_flags", 16'(got.frame_flags), 16'(want.frame_flags));
         if (got.sequence_res != want.sequence_res)
            report("sequence_res", got.sequence_res, want.sequence_res);
         if (got.payload_length != want.payload_length)
            report("payload_length", 16'(got.payload_length), 16'(want.payload_length));
         if (got.payload_byte != want.payload_byte)
            report("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
         if (got.byte_valid != want.byte_valid)
            report("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
         if (got.last != want.last)
            report("last", 16'(got.last), 16'(want.last));
         if (got.error_total != want.error_total)
            report("error_total", got.error_total, want.error_total);
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [7:0]           rsp_frame_type;
   logic [7:0]           rsp_frame_flags;
   logic [15:0]          rsp_sequence_res;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last;
   logic [15:0]          rsp_error_total;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   bit              gap_mode;
   frame_scoreboard sb = new();

   frame_deframer_crc16_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_frame_type(rsp_frame_type),
      .rsp_frame_flags(rsp_frame_flags),
      .rsp_sequence_res(rsp_sequence_res),
      .rsp_payload_length(rsp_payload_length),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_last(rsp_last),
      .rsp_error_total(rsp_error_total),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!gap_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_frame(ref logic [7:0] q[$], input logic [7:0] version,
                                     input logic [15:0] length, input bit header_only,
                                     input bit bad_crc);
      logic [7:0]  hdr [HEADER_BYTES];
      logic [15:0] crc;
      logic [7:0]  b;
      hdr[HDR_VERSION] = version;
      hdr[HDR_TYPE]    = 8'($urandom);
      hdr[HDR_FLAGS]   = 8'($urandom);
      hdr[HDR_SEQ_LO]  = 8'($urandom);
      hdr[HDR_SEQ_HI]  = 8'($urandom);
      hdr[HDR_LEN_LO]  = length[7:0];
      hdr[HDR_LEN_HI]  = length[15:8];
      q.insert(q.size(), SOF_A);
      q.insert(q.size(), SOF_B);
      crc = CRC_INIT;
      foreach (hdr[i]) begin
         q.insert(q.size(), hdr[i]);
         crc = sb.crc_update(crc, hdr[i]);
      end
      if (header_only) begin
         return;
      end
      for (int i = 0; i < length; i++) begin
         b = 8'($urandom);
         q.insert(q.size(), b);
         crc = sb.crc_update(crc, b);
      end
      if (bad_crc) begin
         crc = crc ^ (16'd1 << $urandom_range(0, 15));
      end
      q.insert(q.size(), crc[7:0]);
      q.insert(q.size(), crc[15:8]);
   endfunction

   function automatic void add_random_frames(ref logic [7:0] q[$], input int unsigned nbytes);
      logic [7:0]  partial [$];
      logic [7:0]  ver;
      logic [15:0] len;
      logic [15:0] big;
      int unsigned cap;
      int unsigned pick;
      int unsigned cut;
      cap = (sb.len_limit_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : sb.len_limit_reg;
      while (q.size() < nbytes) begin
         pick = $urandom_range(0, 99);
         ver  = sb.version_req;
         if (cap == 0) begin
            len = '0;
         end else if (cap > 8 && $urandom_range(0, 4) != 0) begin
            len = 16'($urandom_range(0, 8));
         end else begin
            len = 16'($urandom_range(0, cap));
         end
         if (pick < 8) begin
            repeat ($urandom_range(1, 4)) begin
               q.insert(q.size(), $urandom_range(0, 1) ? SOF_A : 8'($urandom));
            end
         end else if (pick < 18) begin
            do ver = 8'($urandom); while (ver == sb.version_req);
            add_frame(q, ver, len, 1'b1, 1'b0);
         end else if (pick < 28) begin
            if ($urandom_range(0, 3) == 0) begin
               big = 16'($urandom_range(cap + 1, 16'hFFFF));
            end else begin
               big = 16'(cap + 1 + $urandom_range(0, 2));
            end
            add_frame(q, ver, big, 1'b1, 1'b0);
         end else if (pick < 38) begin
            add_frame(q, ver, len, 1'b0, 1'b1);
         end else if (pick < 43) begin
            partial.delete();
            add_frame(partial, ver, len, 1'b0, 1'b0);
            cut = $urandom_range(3, partial.size() - 1);
            for (int i = 0; i < cut; i++) begin
               q.insert(q.size(), partial[i]);
            end
         end else begin
            if (pick < 53) begin
               repeat ($urandom_range(1, 2)) q.insert(q.size(), SOF_A);
            end
            add_frame(q, ver, len, 1'b0, 1'b0);
         end
      end
   endfunction

   // call right after a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_stream(input logic [7:0] q[$]);
      foreach (q[i]) begin
         send_byte(q[i]);
      end
      // flush any frame left open so the block ends up hunting again
      while (!sb.hunting()) begin
         send_byte(8'h00);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [7:0] version, input logic [7:0] max_len,
                            input bit gaps, input int unsigned nbytes,
                            input bit with_max_frame);
      logic [7:0] q [$];
      wait_drained();
      write_reg(CSR_FRAME_VERSION, version);
      write_reg(CSR_MAX_PAYLOAD_LEN, max_len);
      gap_mode = gaps;
      if (with_max_frame) begin
         add_frame(q, version, 16'(MAX_PAYLOAD), 1'b0, 1'b0);
      end
      add_random_frames(q, nbytes);
      send_stream(q);
   endtask

   initial begin
      int unsigned hold;
      rsp_ready = 1'b0;
      hold      = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      frame_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_byte(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got.status         = rsp_status;
            got.frame_type     = rsp_frame_type;
            got.frame_flags    = rsp_frame_flags;
            got.sequence_res   = rsp_sequence_res;
            got.payload_length = rsp_payload_length;
            got.payload_byte   = rsp_payload_byte;
            got.byte_valid     = rsp_byte_valid;
            got.last           = rsp_last;
            got.error_total    = rsp_error_total;
            sb.check_result(got);
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAIL frame_deframer_crc16_core");
      $finish;
   end

   initial begin
      logic [7:0] q [$];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      gap_mode     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, broken hunt, repeated start byte, empty frame, version reject
      q = {8'h00, 8'hFF, SOF_A, 8'h12, SOF_A, SOF_A};
      add_frame(q, 8'd1, 16'd0, 1'b0, 1'b0);
      add_frame(q, 8'hFE, 16'd0, 1'b1, 1'b0);
      send_stream(q);

      run_phase(8'h00, 8'd0, 1'b1, 50, 1'b0);
      run_phase(8'hFF, 8'd127, 1'b1, 80, 1'b1);
      run_phase(8'($urandom), 8'($urandom_range(1, 63)), 1'b0, 50, 1'b0);
      run_phase(8'd1, 8'd64, 1'b1, 78, 1'b1);

      // error result followed by a good frame
      wait_drained();
      gap_mode = 1'b0;
      q.delete();
      add_frame(q, 8'h00, 16'd0, 1'b1, 1'b0);
      add_frame(q, 8'd1, 16'd3, 1'b0, 1'b0);
      send_stream(q);
      wait_drained();

      $display("run covered %0d bytes, %0d good frames, %0d error results, %0d results checked",
               sb.bytes_taken, sb.good_frames, sb.bad_frames, sb.results_seen);
      $display("versions 0/1/255/random, length limits 0/64/127/random, error count at 0x%0h",
               sb.error_count);
      if (sb.mismatches == 0) begin
         $display("PASS frame_deframer_crc16_core");
      end else begin
         $display("FAIL frame_deframer_crc16_core");
      end
      $finish;
   end

endmodule
